/* sv/dmx_pkg.sv */
`timescale 1ns / 1ps

package dmx_pkg;

	typedef enum logic [1:0] {
		OP_RX   = 2'd0,
		OP_TICK = 2'd1,
		OP_POP  = 2'd2,
		OP_READ = 2'd3
	} op_e_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam int          MIN_GOOD_LEN  = 5;
	localparam logic [10:0] AGE_MAX       = 11'h7FF;
	localparam logic [9:0]  TIMEOUT_RESET = 10'd200;

	localparam logic [0:0] REG_FRAME_TIMEOUT = 1'b0;

	typedef struct packed {
		logic       fifo_rd;
		logic       line_rd;
		logic [6:0] fifo_level;
		logic       fifo_dropped;
		logic       frame_done;
		logic       frame_good;
		logic [6:0] frame_length;
		logic       in_frame;
	} res_t;

endpackage

/* sv/dmx_ram.sv */
`timescale 1ns / 1ps

module dmx_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/dmx_ctrl.sv */
`timescale 1ns / 1ps

module dmx_ctrl #(
	parameter int FIFO_DEPTH = 64,
	parameter int LINE_DEPTH = 128,
	parameter int FAW        = 6,
	parameter int LAW        = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  dmx_pkg::op_e_t   operation,
	input  logic [7:0]       rx_byte,
	input  logic [6:0]       line_index,
	input  logic [9:0]       timeout,
	output logic             fifo_we,
	output logic [FAW-1:0]   fifo_waddr,
	output logic             fifo_re,
	output logic [FAW-1:0]   fifo_raddr,
	output logic             line_we,
	output logic [LAW-1:0]   line_waddr,
	output logic             line_re,
	output logic [LAW-1:0]   line_raddr,
	output dmx_pkg::res_t    res
);
	import dmx_pkg::*;

	localparam int CNTW = $clog2(FIFO_DEPTH + 1);
	localparam int IW   = (LAW > 7) ? LAW : 7;

	logic [FAW-1:0]  head_q, head_n;
	logic [FAW-1:0]  tail_q, tail_n;
	logic [CNTW-1:0] count_q, count_n;
	logic [LAW-1:0]  fill_q, fill_n;
	logic [LAW-1:0]  last_len_q, last_len_n;
	logic            collecting_q, collecting_n;
	logic            prefix_q, prefix_n;
	logic [10:0]     age_q, age_n;
	logic [IW-1:0]   idx_ext;
	logic [IW-1:0]   len_ext;
	logic [LAW-1:0]  fill_inc;
	logic            eol;
	logic            full;
	logic            tmo;
	logic            dropped;
	logic            done;
	logic            good;

	assign idx_ext  = IW'(line_index);
	assign len_ext  = IW'(last_len_q);
	assign fill_inc = fill_q + LAW'(1);

	always_comb begin
		head_n       = head_q;
		tail_n       = tail_q;
		count_n      = count_q;
		fill_n       = fill_q;
		last_len_n   = last_len_q;
		collecting_n = collecting_q;
		prefix_n     = prefix_q;
		age_n        = age_q;
		fifo_we      = 1'b0;
		fifo_re      = 1'b0;
		line_we      = 1'b0;
		line_re      = 1'b0;
		fifo_waddr   = tail_q;
		fifo_raddr   = head_q;
		line_waddr   = fill_q;
		line_raddr   = idx_ext[LAW-1:0];
		dropped      = 1'b0;
		done         = 1'b0;
		good         = 1'b0;
		eol          = (rx_byte == CH_LF);
		full         = 1'b0;
		tmo          = (age_q > {1'b0, timeout});
		unique case (operation)
			OP_RX: begin
				if (collecting_q) begin
					if (fill_q < LAW'(LINE_DEPTH - 1)) begin
						line_we = 1'b1;
						fill_n  = fill_inc;
						if (fill_q == LAW'(1)) begin
							prefix_n = prefix_q && (rx_byte == CH_W);
						end else if (fill_q == LAW'(2)) begin
							prefix_n = prefix_q && (rx_byte == CH_M);
						end else if (fill_q == LAW'(3)) begin
							prefix_n = prefix_q && (rx_byte == CH_COMMA);
						end
					end
					full = (fill_n >= LAW'(LINE_DEPTH - 1));
					if (eol || full || tmo) begin
						done         = 1'b1;
						good         = eol && (fill_n >= LAW'(MIN_GOOD_LEN)) && prefix_n;
						last_len_n   = fill_n;
						collecting_n = 1'b0;
						fill_n       = '0;
					end
				end else if (rx_byte == CH_DOLLAR) begin
					collecting_n = 1'b1;
					age_n        = '0;
					line_we      = 1'b1;
					line_waddr   = '0;
					fill_n       = LAW'(1);
					prefix_n     = 1'b1;
				end else if (count_q == CNTW'(FIFO_DEPTH)) begin
					dropped = 1'b1;
				end else begin
					fifo_we = 1'b1;
					tail_n  = (tail_q == FAW'(FIFO_DEPTH - 1)) ? '0 : tail_q + FAW'(1);
					count_n = count_q + CNTW'(1);
				end
			end
			OP_TICK: begin
				if (age_q != AGE_MAX) begin
					age_n = age_q + 11'd1;
				end
			end
			OP_POP: begin
				if (count_q != '0) begin
					fifo_re = 1'b1;
					head_n  = (head_q == FAW'(FIFO_DEPTH - 1)) ? '0 : head_q + FAW'(1);
					count_n = count_q - CNTW'(1);
				end
			end
			OP_READ: begin
				if (idx_ext < len_ext) begin
					line_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
		fifo_we = fifo_we && accept;
		fifo_re = fifo_re && accept;
		line_we = line_we && accept;
		line_re = line_re && accept;
	end

	always_comb begin
		res.fifo_rd      = fifo_re;
		res.line_rd      = line_re;
		res.fifo_level   = 7'(count_n);
		res.fifo_dropped = dropped;
		res.frame_done   = done;
		res.frame_good   = good;
		res.frame_length = 7'(last_len_n);
		res.in_frame     = collecting_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			fill_q       <= '0;
			last_len_q   <= '0;
			collecting_q <= 1'b0;
			prefix_q     <= 1'b0;
			age_q        <= '0;
		end else if (accept) begin
			head_q       <= head_n;
			tail_q       <= tail_n;
			count_q      <= count_n;
			fill_q       <= fill_n;
			last_len_q   <= last_len_n;
			collecting_q <= collecting_n;
			prefix_q     <= prefix_n;
			age_q        <= age_n;
		end
	end

endmodule

/* sv/dmx_out.sv */
`timescale 1ns / 1ps

module dmx_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  dmx_pkg::res_t res,
	input  logic [7:0]    fifo_rdata,
	input  logic [7:0]    line_rdata,
	output logic          busy,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    fifo_byte,
	output logic [7:0]    line_byte,
	output logic [6:0]    fifo_level,
	output logic          fifo_dropped,
	output logic          frame_done,
	output logic          frame_good,
	output logic [6:0]    frame_length,
	output logic          in_frame
);
	import dmx_pkg::*;

	logic valid_s1;
	res_t res_s1;
	logic adv;

	assign adv  = valid_s1 && (!out_valid || !out_stall);
	assign busy = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fifo_byte    <= res_s1.fifo_rd ? fifo_rdata : 8'd0;
			line_byte    <= res_s1.line_rd ? line_rdata : 8'd0;
			fifo_level   <= res_s1.fifo_level;
			fifo_dropped <= res_s1.fifo_dropped;
			frame_done   <= res_s1.frame_done;
			frame_good   <= res_s1.frame_good;
			frame_length <= res_s1.frame_length;
			in_frame     <= res_s1.in_frame;
		end
	end

endmodule

/* sv/ascii_binary_stream_demux_top.sv */
`timescale 1ns / 1ps

// Splits a received byte stream into a binary FIFO and an ASCII frame store.
// The input channel (in_valid, in_stall) carries one operation per beat: a
// received byte, a millisecond tick, a FIFO pop or a frame store read.
// Every accepted beat yields exactly one result beat on the output channel
// (out_valid, out_stall) with the popped or read byte and the status flags.
// An accepted beat's result passes through the registered read of the FIFO or
// frame memory and then the output register. The block sustains one beat per
// cycle while the receiver does not stall; each beat makes at most one access
// to each memory, so no two beats contend for a memory port.
// When the receiver stalls, the output register and the memory read stage
// both fill, and then in_stall rises until the receiver takes a result.
// Reset empties the FIFO, closes any open frame, clears the frame length and
// age, and sets the frame timeout register to 200 ms. The memories are not
// cleared; nothing can read an entry that was never written.
// The frame timeout is written through the APB port at any address with paddr[2] clear.

module ascii_binary_stream_demux_top #(
	parameter int FIFO_DEPTH = 64,
	parameter int LINE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	input  logic [6:0]  line_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  fifo_byte,
	output logic [7:0]  line_byte,
	output logic [6:0]  fifo_level,
	output logic        fifo_dropped,
	output logic        frame_done,
	output logic        frame_good,
	output logic [6:0]  frame_length,
	output logic        in_frame
);
	import dmx_pkg::*;

	localparam int FAW = $clog2(FIFO_DEPTH);
	localparam int LAW = $clog2(LINE_DEPTH);

	logic [9:0]     timeout_q;
	logic           accept;
	logic           busy;
	logic           fifo_we;
	logic [FAW-1:0] fifo_waddr;
	logic           fifo_re;
	logic [FAW-1:0] fifo_raddr;
	logic [7:0]     fifo_rdata;
	logic           line_we;
	logic [LAW-1:0] line_waddr;
	logic           line_re;
	logic [LAW-1:0] line_raddr;
	logic [7:0]     line_rdata;
	res_t           res;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_FRAME_TIMEOUT) ? {22'd0, timeout_q} : 32'd0;
	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_TIMEOUT) begin
			timeout_q <= pwdata[9:0];
		end
	end

	dmx_ctrl #(
		.FIFO_DEPTH(FIFO_DEPTH),
		.LINE_DEPTH(LINE_DEPTH),
		.FAW       (FAW),
		.LAW       (LAW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (op_e_t'(operation)),
		.rx_byte   (rx_byte),
		.line_index(line_index),
		.timeout   (timeout_q),
		.fifo_we   (fifo_we),
		.fifo_waddr(fifo_waddr),
		.fifo_re   (fifo_re),
		.fifo_raddr(fifo_raddr),
		.line_we   (line_we),
		.line_waddr(line_waddr),
		.line_re   (line_re),
		.line_raddr(line_raddr),
		.res       (res)
	);

	dmx_ram #(
		.DEPTH(FIFO_DEPTH),
		.AW   (FAW)
	) u_fifo_ram (
		.clk  (clk),
		.we   (fifo_we),
		.waddr(fifo_waddr),
		.wdata(rx_byte),
		.re   (fifo_re),
		.raddr(fifo_raddr),
		.rdata(fifo_rdata)
	);

	dmx_ram #(
		.DEPTH(LINE_DEPTH),
		.AW   (LAW)
	) u_line_ram (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_waddr),
		.wdata(rx_byte),
		.re   (line_re),
		.raddr(line_raddr),
		.rdata(line_rdata)
	);

	dmx_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.res         (res),
		.fifo_rdata  (fifo_rdata),
		.line_rdata  (line_rdata),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fifo_byte   (fifo_byte),
		.line_byte   (line_byte),
		.fifo_level  (fifo_level),
		.fifo_dropped(fifo_dropped),
		.frame_done  (frame_done),
		.frame_good  (frame_good),
		.frame_length(frame_length),
		.in_frame    (in_frame)
	);

endmodule
